// ----- src/tec_pkg.sv -----
// package with the class codes and byte masks of the text encoding classifier
`default_nettype none

package tec_pkg;

  typedef enum logic [1:0] {
    CLASS_ASCII  = 2'd0,
    CLASS_UTF8   = 2'd1,
    CLASS_CP1252 = 2'd2
  } enc_class_e;

  localparam int unsigned CodePointW = 21;
  localparam int unsigned DataW      = 8;

  localparam logic [7:0] ContMask  = 8'hC0;
  localparam logic [7:0] ContMark  = 8'h80;
  localparam logic [7:0] ContBits  = 8'h3F;
  localparam logic [7:0] Lead2Bits = 8'h1F;
  localparam logic [7:0] Lead3Bits = 8'h0F;
  localparam logic [7:0] Lead4Bits = 8'h07;

  // noncharacter test over the full code point width
  function automatic logic is_nonchar(input logic [CodePointW-1:0] cp);
    logic in_block;
    logic low_pair;
    begin
      in_block = (cp >= 21'h00FDD0) && (cp <= 21'h00FDEF);
      low_pair = (cp[15:1] == 15'h7FFF);
      return in_block || low_pair;
    end
  endfunction

endpackage

`default_nettype wire

// ----- src/text_encoding_classifier_core.sv -----
// top level of the text encoding classifier: per-byte utf-8 check and result register
// result: the class is registered on the last byte's transfer and appears on the master side in the cycle after it
// throughput: one byte per cycle; the slave side stalls only while a result is held
// and the master side is not ready
// reset: asynchronous, clears the decode state and drops any held result
`default_nettype none

module text_encoding_classifier_core (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  input  wire logic [7:0] s_axis_tdata_i,   // [7:0] data_byte
  input  wire logic       s_axis_tlast_i,   // last_byte
  output logic            m_axis_tvalid_o,
  input  wire logic       m_axis_tready_i,
  output logic      [7:0] m_axis_tdata_o    // [1:0] encoding_class, [7:2] zero
);

  logic [1:0]                         pend_q, pend_d;
  logic [tec_pkg::CodePointW-1:0]     cp_q, cp_d;
  logic                               non_ascii_q, non_ascii_d;
  logic                               broken_q, broken_d;
  logic                               out_valid_q, out_valid_d;
  tec_pkg::enc_class_e                out_class_q, out_class_d;

  logic [7:0]                         b;
  logic                               s_xfer;
  logic [1:0]                         tb_pend;
  logic [tec_pkg::CodePointW-1:0]     tb_cp;
  logic [tec_pkg::CodePointW-1:0]     cp_shift;
  logic                               tb_non_ascii;
  logic                               tb_broken;
  logic                               fin_broken;

  assign b               = s_axis_tdata_i;
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign s_xfer          = s_axis_tvalid_i && s_axis_tready_o;
  assign cp_shift        = {cp_q[tec_pkg::CodePointW-7:0], b[5:0]};

  // effect of one byte on the decode state
  always_comb begin
    tb_pend      = pend_q;
    tb_cp        = cp_q;
    tb_non_ascii = non_ascii_q;
    tb_broken    = broken_q;
    if (!broken_q) begin
      if (pend_q != 2'd0) begin
        if ((b & tec_pkg::ContMask) != tec_pkg::ContMark) begin
          tb_broken = 1'b1;
          tb_pend   = 2'd0;
        end else begin
          tb_cp   = cp_shift;
          tb_pend = pend_q - 2'd1;
          if ((pend_q == 2'd1) && tec_pkg::is_nonchar(cp_shift)) begin
            tb_broken = 1'b1;
          end
        end
      end else if (b[7]) begin
        tb_non_ascii = 1'b1;
        if (!b[6]) begin
          tb_broken = 1'b1;
        end else if (!b[5]) begin
          tb_pend = 2'd1;
          tb_cp   = {13'd0, b & tec_pkg::Lead2Bits};
        end else if (!b[4]) begin
          tb_pend = 2'd2;
          tb_cp   = {13'd0, b & tec_pkg::Lead3Bits};
        end else if (!b[3]) begin
          tb_pend = 2'd3;
          tb_cp   = {13'd0, b & tec_pkg::Lead4Bits};
        end else begin
          tb_broken = 1'b1;
        end
      end
    end
  end

  always_comb begin
    fin_broken  = tb_broken || (tb_pend != 2'd0);
    pend_d      = pend_q;
    cp_d        = cp_q;
    non_ascii_d = non_ascii_q;
    broken_d    = broken_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_class_d = out_class_q;
    if (s_xfer) begin
      if (s_axis_tlast_i) begin
        pend_d      = 2'd0;
        cp_d        = '0;
        non_ascii_d = 1'b0;
        broken_d    = 1'b0;
        out_valid_d = 1'b1;
        if (!tb_non_ascii) begin
          out_class_d = tec_pkg::CLASS_ASCII;
        end else if (fin_broken) begin
          out_class_d = tec_pkg::CLASS_CP1252;
        end else begin
          out_class_d = tec_pkg::CLASS_UTF8;
        end
      end else begin
        pend_d      = tb_pend;
        cp_d        = tb_cp;
        non_ascii_d = tb_non_ascii;
        broken_d    = tb_broken;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= 2'd0;
      cp_q        <= '0;
      non_ascii_q <= 1'b0;
      broken_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pend_q      <= pend_d;
      cp_q        <= cp_d;
      non_ascii_q <= non_ascii_d;
      broken_q    <= broken_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_class_q <= out_class_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'd0, out_class_q};

endmodule

`default_nettype wire

// ----- src/tec_checker.sv -----
// port-level checker for the text encoding classifier and its bind
`default_nettype none

module tec_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       s_axis_tvalid_i,
  input wire logic       s_axis_tready_o,
  input wire logic       s_axis_tlast_i,
  input wire logic       m_axis_tvalid_o,
  input wire logic       m_axis_tready_i,
  input wire logic [7:0] m_axis_tdata_o
);

  logic s_xfer;
  assign s_xfer = s_axis_tvalid_i && s_axis_tready_o;

  // a result only follows a last-byte transfer
  a_result_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(s_xfer && s_axis_tlast_i))
    else $error("result without last-byte transfer");

  // a non-last byte never produces a result once the output drains
  a_no_result_mid_file: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_xfer && !s_axis_tlast_i && (!m_axis_tvalid_o || m_axis_tready_i)) |=> !m_axis_tvalid_o)
    else $error("result on a non-last byte");

  // slave side never stalls while the output is empty
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input stalled with empty output");

  // held result stays put
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> (m_axis_tvalid_o && $stable(m_axis_tdata_o)))
    else $error("stalled result changed");

  // only the three class codes with zero padding
  a_code_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> ((m_axis_tdata_o[7:2] == 6'd0) && (m_axis_tdata_o[1:0] != 2'd3)))
    else $error("bad class code");

endmodule

bind text_encoding_classifier_core tec_checker u_tec_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tlast_i  (s_axis_tlast_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

`default_nettype wire
